[rtl/core/mrc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types, constants and the byte-wise CRC-16 update for the Modbus RTU
// response checker.
// ----------------------------------------------------------------------------
package mrc_pkg;

  localparam int DataBytes = 8;              // data bytes packed into the value
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [7:0]  PosCount = 8'd2;   // frame position of the count byte
  localparam logic [7:0]  PosData = 8'd3;    // first data byte position
  localparam logic [7:0]  PosMax = 8'hFF;
  localparam logic [1:0]  HeldFull = 2'd2;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } item_t;

  typedef struct packed {
    logic        crc_ok;
    logic [7:0]  data_count;
    logic [63:0] data_value;
  } result_t;

  // one byte through the reflected modbus crc, bit by bit
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[rtl/core/mrc_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_in_stage
// Input register. Holds one item and hands it on when the frame logic can
// take it; only a frame-end item waits for a free result slot.
// ----------------------------------------------------------------------------
module mrc_in_stage
  import mrc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  [7:0] rx_byte,
  input  logic  frame_end,
  input  logic  out_free,
  output logic  go,
  output item_t item
);

  logic held_valid;

  assign go       = held_valid && (!item.frame_end || out_free);
  assign in_ready = !held_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.rx_byte   <= rx_byte;
      item.frame_end <= frame_end;
    end
  end

endmodule

[rtl/core/mrc_frame_state.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_frame_state
// Frame state and per-byte update: crc over all but the trailing two bytes,
// count byte capture and little-endian packing of the data bytes.
// ----------------------------------------------------------------------------
module mrc_frame_state
  import mrc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    go,
  input  item_t   item,
  output logic    res_valid,
  output result_t res
);

  logic [15:0] crc_acc, crc_acc_next;
  logic [7:0]  byte_position, byte_position_next;
  logic [15:0] held_bytes, held_bytes_next;
  logic [1:0]  held_count, held_count_next;
  logic [7:0]  count_field, count_field_next;
  logic [63:0] value_acc, value_acc_next;
  logic [7:0]  body_pos;
  logic [7:0]  k;

  always_comb begin
    crc_acc_next     = crc_acc;
    held_bytes_next  = held_bytes;
    held_count_next  = held_count;
    value_acc_next   = value_acc;
    count_field_next = (byte_position == PosCount) ? item.rx_byte : count_field;
    body_pos         = byte_position - 8'd2;
    k                = body_pos - PosData;

    if (held_count >= HeldFull) begin
      // oldest held byte is now known to be body, not crc
      crc_acc_next = crc_feed(crc_acc, held_bytes[7:0]);
      if (body_pos >= PosData && k < count_field_next && k < 8'(DataBytes)) begin
        value_acc_next = value_acc | ({56'd0, held_bytes[7:0]} << {k[2:0], 3'b000});
      end
      held_bytes_next = {item.rx_byte, held_bytes[15:8]};
    end else if (held_count == 2'd1) begin
      held_bytes_next = {item.rx_byte, held_bytes[7:0]};
      held_count_next = HeldFull;
    end else begin
      held_bytes_next = {8'h00, item.rx_byte};
      held_count_next = 2'd1;
    end

    byte_position_next = (byte_position != PosMax) ? byte_position + 8'd1 : byte_position;

    res_valid      = go && item.frame_end;
    res.crc_ok     = (held_count_next == HeldFull) && (held_bytes_next == crc_acc_next);
    res.data_count = count_field_next;
    res.data_value = value_acc_next;
  end

  always_ff @(posedge clk) begin
    if (rst || res_valid) begin
      crc_acc       <= CrcInit;
      byte_position <= 8'd0;
      held_bytes    <= 16'd0;
      held_count    <= 2'd0;
      count_field   <= 8'd0;
      value_acc     <= 64'd0;
    end else if (go) begin
      crc_acc       <= crc_acc_next;
      byte_position <= byte_position_next;
      held_bytes    <= held_bytes_next;
      held_count    <= held_count_next;
      count_field   <= count_field_next;
      value_acc     <= value_acc_next;
    end
  end

endmodule

[rtl/core/mrc_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_out_stage
// Result register. Holds one finished result until the consumer takes it.
// ----------------------------------------------------------------------------
module mrc_out_stage
  import mrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        res_valid,
  input  result_t     res,
  output logic        out_free,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        crc_ok,
  output logic [7:0]  data_count,
  output logic [63:0] data_value
);

  result_t held;

  assign out_free   = !out_valid || out_ready;
  assign crc_ok     = held.crc_ok;
  assign data_count = held.data_count;
  assign data_value = held.data_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      held <= res;
    end
  end

endmodule

[rtl/core/modbus_rtu_response_checker_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker_unit
// Checks a modbus rtu response frame byte by byte and reports crc status,
// the count byte and up to eight packed data bytes at the frame end.
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------------------------
//   in       | in_valid/in_ready   | rx_byte[7:0], frame_end
//   out      | out_valid/out_ready | crc_ok, data_count[7:0], data_value[63:0]
//
// one byte accepted per cycle unless stalled; a byte is processed from the input register,
// so a frame-end result enters the result register when its byte leaves the input stage.
// only a frame-end item stalls, and only while an earlier result is still untaken.
// reset clears all frame state; the block is ready right after reset.
// after each result the frame state returns to its reset values.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker_unit
  import mrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        crc_ok,
  output logic [7:0]  data_count,
  output logic [63:0] data_value
);

  item_t   item;
  result_t res;
  logic    go;
  logic    out_free;
  logic    res_valid;

  mrc_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .frame_end(frame_end),
    .out_free (out_free),
    .go       (go),
    .item     (item)
  );

  mrc_frame_state u_state (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .item     (item),
    .res_valid(res_valid),
    .res      (res)
  );

  mrc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .crc_ok    (crc_ok),
    .data_count(data_count),
    .data_value(data_value)
  );

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!out_valid || out_ready))
    else $error("result written over an untaken result");

  // a body byte never stalls
  a_body_flows: assert property (@(posedge clk) disable iff (rst)
    (!in_ready) |-> (item.frame_end && out_valid && !out_ready))
    else $error("input stalled without a pending frame end");

  // a taken result clears the output unless a new one lands
  a_out_drains: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !res_valid) |=> !out_valid)
    else $error("result still shown after it was taken");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Sends modbus rtu response frames byte by byte into the response checker and
// checks every frame-end result against a local model of the crc, count and
// data packing. Both handshakes see random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import mrc_pkg::*;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_CRC,
    FRAME_RAW
  } frame_kind_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        frame_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        crc_ok;
  logic [7:0]  data_count;
  logic [63:0] data_value;

  item_t       pending_bytes[$];
  logic [7:0]  frame_buf[$];
  result_t     due_results[$];
  int          mismatches = 0;

  // model of the frame state
  logic [15:0] m_crc;
  logic [7:0]  m_pos;
  logic [15:0] m_hold;
  logic [1:0]  m_held;
  logic [7:0]  m_count;
  logic [63:0] m_value;

  logic        in_acc = 1'b0;
  logic        out_acc = 1'b0;
  int          in_gap = 0;
  int          out_stall = 0;
  int          in_calm = 0;
  int          out_calm = 0;

  modbus_rtu_response_checker_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .frame_end  (frame_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .crc_ok     (crc_ok),
    .data_count (data_count),
    .data_value (data_value)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    repeat (8) begin
      r = r[0] ? ({1'b0, r[15:1]} ^ CrcPoly) : {1'b0, r[15:1]};
    end
    return r;
  endfunction

  // mostly no gap, some short, a few long, now and then a calm stretch
  function automatic int pick_gap(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic clear_frame();
    m_crc = CrcInit;
    m_pos = '0;
    m_hold = '0;
    m_held = '0;
    m_count = '0;
    m_value = '0;
  endtask

  task automatic track_frame_byte(input logic [7:0] b, input logic last);
    logic [7:0] oldest;
    int k;
    result_t r;
    if (m_pos == PosCount) m_count = b;
    if (m_held >= HeldFull) begin
      // the oldest held byte is now known to be body, not crc
      oldest = m_hold[7:0];
      m_crc = crc_next(m_crc, oldest);
      k = int'(m_pos) - 2 - int'(PosData);
      if (k >= 0 && k < int'(m_count) && k < DataBytes) begin
        m_value = m_value | (64'(oldest) << (8 * k));
      end
      m_hold = {b, m_hold[15:8]};
    end else if (m_held == 2'd1) begin
      m_hold[15:8] = b;
      m_held = HeldFull;
    end else begin
      m_hold = {8'h00, b};
      m_held = 2'd1;
    end
    if (m_pos != PosMax) m_pos++;
    if (last) begin
      r.crc_ok = (m_held == HeldFull) && (m_hold == m_crc);
      r.data_count = m_count;
      r.data_value = m_value;
      due_results.push_back(r);
      clear_frame();
    end
  endtask

  // append crc (or not) to the bytes in frame_buf and queue them as items
  task automatic emit_frame(input frame_kind_e kind);
    logic [15:0] c;
    item_t it;
    int n;
    c = CrcInit;
    if (kind != FRAME_RAW) begin
      foreach (frame_buf[i]) c = crc_next(c, frame_buf[i]);
      if (kind == FRAME_BAD_CRC) c = c ^ (16'h0001 << $urandom_range(0, 15));
      frame_buf.push_back(c[7:0]);
      frame_buf.push_back(c[15:8]);
    end
    n = frame_buf.size();
    for (int i = 0; i < n; i++) begin
      it.rx_byte = frame_buf[i];
      it.frame_end = (i == n - 1);
      pending_bytes.push_back(it);
    end
    frame_buf.delete();
  endtask

  task automatic build_random_frame(input bit long_frame);
    int roll;
    int nd;
    frame_kind_e kind;
    roll = $urandom_range(0, 99);
    kind = ($urandom_range(0, 99) < 80) ? FRAME_GOOD : FRAME_BAD_CRC;
    if (roll < 8) begin
      // noise: a few random bytes, usually too short or with a bad crc
      repeat ($urandom_range(1, 4)) frame_buf.push_back(8'($urandom_range(0, 255)));
      emit_frame(FRAME_RAW);
    end else if (roll < 14) begin
      // body too short to hold a count byte
      repeat ($urandom_range(0, 2)) frame_buf.push_back(8'($urandom_range(0, 255)));
      emit_frame(kind);
    end else begin
      nd = long_frame ? $urandom_range(260, 300) : $urandom_range(0, 12);
      frame_buf.push_back(8'($urandom_range(0, 255)));
      frame_buf.push_back(8'($urandom_range(0, 255)));
      roll = $urandom_range(0, 99);
      if (roll < 65) frame_buf.push_back(8'(nd));
      else if (roll < 75) frame_buf.push_back(8'hFF);
      else frame_buf.push_back(8'($urandom_range(0, 255)));
      repeat (nd) frame_buf.push_back(8'($urandom_range(0, 255)));
      emit_frame(kind);
    end
  endtask

  // item driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        rx_byte <= pending_bytes[0].rx_byte;
        frame_end <= pending_bytes[0].frame_end;
        void'(pending_bytes.pop_front());
        in_valid <= 1'b1;
        in_gap <= pick_gap(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (out_acc || $urandom_range(0, 7) == 0) out_stall <= pick_gap(out_calm);
    end
  end

  // accepted items feed the model
  always @(posedge clk) begin
    in_acc <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) track_frame_byte(rx_byte, frame_end);
  end

  // result monitor
  always @(posedge clk) begin
    out_acc <= !rst && out_valid && out_ready;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: crc_ok %0d data_count %0d data_value %h",
               crc_ok, data_count, data_value);
        mismatches++;
      end else begin
        if (crc_ok !== due_results[0].crc_ok) begin
          $error("crc_ok: expected %0d, got %0d", due_results[0].crc_ok, crc_ok);
          mismatches++;
        end
        if (data_count !== due_results[0].data_count) begin
          $error("data_count: expected %0d, got %0d", due_results[0].data_count, data_count);
          mismatches++;
        end
        if (data_value !== due_results[0].data_value) begin
          $error("data_value: expected %h, got %h", due_results[0].data_value, data_value);
          mismatches++;
        end
        void'(due_results.pop_front());
      end
    end
  end

  initial begin
    int frame_no;
    clear_frame();

    // one byte frame, then two byte frames with and without the empty-body crc
    frame_buf = '{8'h00};
    emit_frame(FRAME_RAW);
    emit_frame(FRAME_GOOD);
    frame_buf = '{8'hFF, 8'h00};
    emit_frame(FRAME_RAW);
    // count matches the data
    frame_buf = '{8'h01, 8'h03, 8'h02, 8'h12, 8'h34};
    emit_frame(FRAME_GOOD);
    // count runs past the data, crc bytes must not be packed
    frame_buf = '{8'hFF, 8'hFF, 8'h05, 8'hAA};
    emit_frame(FRAME_GOOD);
    // zero count with a corrupted crc
    frame_buf = '{8'h01, 8'h83, 8'h00};
    emit_frame(FRAME_BAD_CRC);

    frame_no = 0;
    while (pending_bytes.size() < 2000) begin
      build_random_frame(frame_no == 40 || frame_no == 150);
      frame_no++;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || in_valid || due_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (due_results.size() != 0) begin
      $error("%0d results never arrived", due_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("modbus_rtu_response_checker_unit: match");
    end else begin
      $display("modbus_rtu_response_checker_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("modbus_rtu_response_checker_unit: mismatch");
    $finish;
  end

endmodule

[sim.f]
rtl/core/mrc_pkg.sv
rtl/core/mrc_in_stage.sv
rtl/core/mrc_frame_state.sv
rtl/core/mrc_out_stage.sv
rtl/core/modbus_rtu_response_checker_unit.sv
sim/tb_top.sv
